>>> hdl/dtq_pkg.sv
// Shared constants, codes and types of the deadline timer queue.
`default_nettype none
package dtq_pkg;

   localparam int TABLE_DEPTH_DEF  = 32;
   localparam int TASK_ID_BITS_DEF = 16;
   localparam int MAX_RESULTS      = 32;

   localparam int TIME_W  = 48;
   localparam int STAMP_W = 16;
   localparam int ID_W    = 16;
   localparam int COUNT_W = 6;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_SCHED  = 2'd1;
   localparam logic [1:0] KIND_CANCEL = 2'd2;

   localparam logic [2:0] ST_FIRED  = 3'd0;
   localparam logic [2:0] ST_SCHED  = 3'd1;
   localparam logic [2:0] ST_FULL   = 3'd2;
   localparam logic [2:0] ST_CANCEL = 3'd3;
   localparam logic [2:0] ST_NONE   = 3'd4;

   typedef struct packed {
      logic [TIME_W-1:0]  deadline;
      logic [STAMP_W-1:0] stamp;
   } dtq_slot_type;

endpackage
`default_nettype wire

>>> hdl/dtq_table.sv
// Entry store of the timer queue: one write port, one registered read port.
`default_nettype none
module dtq_table
   import dtq_pkg::*;
#(
   parameter int DEPTH  = TABLE_DEPTH_DEF,
   parameter int TID_W  = TASK_ID_BITS_DEF,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire dtq_slot_type     wr_slot,
   input  wire logic [TID_W-1:0] wr_task,
   input  wire logic [IDX_W-1:0] rd_addr,
   output dtq_slot_type          rd_slot,
   output logic      [TID_W-1:0] rd_task
);

   dtq_slot_type     slot_mem [DEPTH];
   logic [TID_W-1:0] task_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_slot;
         task_mem[wr_addr] <= wr_task;
      end
      rd_slot <= slot_mem[rd_addr];
      rd_task <= task_mem[rd_addr];
   end

endmodule
`default_nettype wire

>>> hdl/deadline_timer_queue_top.sv
// Top level of the deadline timer queue: sequencer, clock, valid bits and result register.
//
// Usage: one request word on req_* carries a kind (tick, schedule, cancel) with its task,
// delay and elapsed fields. Result words leave on rsp_*, each with a status, task id,
// removal count and a last flag that marks the final word caused by one request.
// Both channels use valid/ready; a word moves when valid and ready are high at a clock edge.
// The block takes one request at a time: req_ready is high only while the sequencer idles.
// Tick and schedule pass one shared 48-bit saturating adder. Schedule then walks the valid
// bits, and tick and cancel walk the table, one slot per cycle; tick and cancel compare
// on the registered read port. Schedule steps: add, free-slot walk, stage, emit.
// Cancel steps: a walk of every slot plus the registered read, stage, emit.
// Tick steps: add, one table walk per fired entry plus a closing walk, and an emit per
// result word; a tick that reaches MAX_RESULTS skips the closing walk.
// A final result waits in the output register while the next request is taken; the
// sequencer stalls only when it must place a new word and the previous one is unread.
// Reset (synchronous, active high) empties the table, zeroes the clock and the insertion
// stamp and drops any result not yet taken; the entry store itself is not cleared.
`default_nettype none
module deadline_timer_queue_top
   import dtq_pkg::*;
#(
   parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
   parameter int TASK_ID_BITS = TASK_ID_BITS_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [1:0]   req_kind,
   input  wire logic [15:0]  req_task_id,
   input  wire logic [31:0]  req_delay_ms,
   input  wire logic [15:0]  req_elapsed_ms,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [15:0]       rsp_fired_id,
   output logic [5:0]        rsp_removed_count,
   output logic              rsp_last
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int N_W   = $clog2(MAX_RESULTS + 1);
   localparam int TID_W = TASK_ID_BITS;

   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_DEPTH);
   localparam logic [N_W-1:0]   N_END   = N_W'(MAX_RESULTS);

   // sequencer states
   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_ADD       = 3'd1;
   localparam logic [2:0] S_SCHED     = 3'd2;
   localparam logic [2:0] S_CANCEL    = 3'd3;
   localparam logic [2:0] S_TICK_NEXT = 3'd4;
   localparam logic [2:0] S_TICK_SCAN = 3'd5;
   localparam logic [2:0] S_EMIT      = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [2:0]         ret_ff, ret_in;
   logic [1:0]         kind_ff, kind_in;
   logic [TID_W-1:0]   id_ff, id_in;
   logic [TIME_W-1:0]  opb_ff, opb_in;
   logic [TIME_W-1:0]  now_ff, now_in;
   logic [TIME_W-1:0]  sdl_ff, sdl_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]   rm_ff, rm_in;
   logic               best_found_ff, best_found_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [TIME_W-1:0]  best_dl_ff, best_dl_in;
   logic [STAMP_W-1:0] best_age_ff, best_age_in;
   logic [TID_W-1:0]   best_task_ff, best_task_in;
   logic               pend_ff, pend_in;
   logic [TID_W-1:0]   pend_task_ff, pend_task_in;
   logic [N_W-1:0]     nfire_ff, nfire_in;
   logic [2:0]         res_status_ff, res_status_in;
   logic [ID_W-1:0]    res_id_ff, res_id_in;
   logic [COUNT_W-1:0] res_count_ff, res_count_in;
   logic               res_last_ff, res_last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;

   // table ports
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   dtq_slot_type     wr_slot;
   logic [IDX_W-1:0] rd_addr;
   dtq_slot_type     rd_slot;
   logic [TID_W-1:0] rd_task;

   // shared unit and walk helpers
   logic [TIME_W:0]    sum_wide;
   logic [TIME_W-1:0]  sum_sat;
   logic [STAMP_W-1:0] age;
   logic               cand;
   logic               better;
   logic               walk_done;
   logic               can_load;
   logic [COUNT_W-1:0] rm_sat;

   dtq_table #(
      .DEPTH (TABLE_DEPTH),
      .TID_W (TID_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_slot (wr_slot),
      .wr_task (id_ff),
      .rd_addr (rd_addr),
      .rd_slot (rd_slot),
      .rd_task (rd_task)
   );

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_fired_id      = rsp_id_ff;
   assign rsp_removed_count = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

   // saturating clock adder, shared by tick and schedule
   assign sum_wide = {1'b0, now_ff} + {1'b0, opb_ff};
   assign sum_sat  = sum_wide[TIME_W] ? TIME_MAX : sum_wide[TIME_W-1:0];

   assign rd_addr = cnt_ff[IDX_W-1:0];
   assign wr_addr = cnt_ff[IDX_W-1:0];
   assign wr_slot = '{deadline: sdl_ff, stamp: stamp_ff};
   assign wr_en   = (state_ff == S_SCHED) && (cnt_ff != CNT_END) && !valid_ff[wr_addr];

   // one comparator over the slot read last cycle
   assign age    = stamp_ff - rd_slot.stamp;
   assign cand   = cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_slot.deadline <= now_ff);
   assign better = !best_found_ff || (rd_slot.deadline < best_dl_ff) ||
                   ((rd_slot.deadline == best_dl_ff) && (age > best_age_ff));

   assign walk_done = (cnt_ff == CNT_END) && !cmp_vld_ff;
   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign rm_sat    = (32'(rm_ff) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(rm_ff);

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      opb_in        = opb_ff;
      now_in        = now_ff;
      sdl_in        = sdl_ff;
      stamp_in      = stamp_ff;
      valid_in      = valid_ff;
      cnt_in        = cnt_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      rm_in         = rm_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_dl_in    = best_dl_ff;
      best_age_in   = best_age_ff;
      best_task_in  = best_task_ff;
      pend_in       = pend_ff;
      pend_task_in  = pend_task_ff;
      nfire_in      = nfire_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_count_in  = res_count_ff;
      res_last_in   = res_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind;
               id_in   = TID_W'(req_task_id);
               opb_in  = (req_kind == KIND_TICK) ? TIME_W'(req_elapsed_ms)
                                                 : TIME_W'(req_delay_ms);
               cnt_in  = '0;
               rm_in   = '0;
               case (req_kind)
                  KIND_TICK,
                  KIND_SCHED:  state_in = S_ADD;
                  KIND_CANCEL: state_in = S_CANCEL;
                  default:     state_in = S_IDLE;  // unknown kind: drop the word
               endcase
            end
         end

         S_ADD: begin
            if (kind_ff == KIND_TICK) begin
               now_in   = sum_sat;
               nfire_in = '0;
               pend_in  = 1'b0;
               state_in = S_TICK_NEXT;
            end else begin
               sdl_in   = sum_sat;
               state_in = S_SCHED;
            end
         end

         S_SCHED: begin
            // walk the valid bits for the lowest free slot
            if (cnt_ff == CNT_END) begin
               res_status_in = ST_FULL;
               res_id_in     = ID_W'(id_ff);
               res_count_in  = '0;
               res_last_in   = 1'b1;
               ret_in        = S_IDLE;
               state_in      = S_EMIT;
            end else if (wr_en) begin
               valid_in[wr_addr] = 1'b1;
               stamp_in          = stamp_ff + 1'b1;
               res_status_in     = ST_SCHED;
               res_id_in         = ID_W'(id_ff);
               res_count_in      = '0;
               res_last_in       = 1'b1;
               ret_in            = S_IDLE;
               state_in          = S_EMIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         S_CANCEL: begin
            if (cnt_ff != CNT_END) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = cnt_ff[IDX_W-1:0];
               cnt_in     = cnt_ff + 1'b1;
            end
            if (cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_task == id_ff)) begin
               valid_in[cmp_idx_ff] = 1'b0;
               rm_in                = rm_ff + 1'b1;
            end
            if (walk_done) begin
               res_status_in = ST_CANCEL;
               res_id_in     = ID_W'(id_ff);
               res_count_in  = rm_sat;
               res_last_in   = 1'b1;
               ret_in        = S_IDLE;
               state_in      = S_EMIT;
            end
         end

         S_TICK_NEXT: begin
            if (nfire_ff == N_END) begin
               // result limit reached: close with the held entry
               res_status_in = ST_FIRED;
               res_id_in     = ID_W'(pend_task_ff);
               res_count_in  = '0;
               res_last_in   = 1'b1;
               ret_in        = S_IDLE;
               state_in      = S_EMIT;
            end else begin
               cnt_in        = '0;
               best_found_in = 1'b0;
               state_in      = S_TICK_SCAN;
            end
         end

         S_TICK_SCAN: begin
            if (cnt_ff != CNT_END) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = cnt_ff[IDX_W-1:0];
               cnt_in     = cnt_ff + 1'b1;
            end
            if (cand && better) begin
               best_found_in = 1'b1;
               best_idx_in   = cmp_idx_ff;
               best_dl_in    = rd_slot.deadline;
               best_age_in   = age;
               best_task_in  = rd_task;
            end
            if (walk_done) begin
               if (best_found_ff) begin
                  // retire the winner now; release the held one as a non-final word
                  valid_in[best_idx_ff] = 1'b0;
                  nfire_in              = nfire_ff + 1'b1;
                  pend_in               = 1'b1;
                  pend_task_in          = best_task_ff;
                  if (pend_ff) begin
                     res_status_in = ST_FIRED;
                     res_id_in     = ID_W'(pend_task_ff);
                     res_count_in  = '0;
                     res_last_in   = 1'b0;
                     ret_in        = S_TICK_NEXT;
                     state_in      = S_EMIT;
                  end else begin
                     state_in = S_TICK_NEXT;
                  end
               end else begin
                  res_status_in = pend_ff ? ST_FIRED : ST_NONE;
                  res_id_in     = pend_ff ? ID_W'(pend_task_ff) : '0;
                  res_count_in  = '0;
                  res_last_in   = 1'b1;
                  ret_in        = S_IDLE;
                  state_in      = S_EMIT;
               end
            end
         end

         S_EMIT: begin
            // hold until the output register is free
            if (can_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               rsp_count_in  = res_count_ff;
               rsp_last_in   = res_last_ff;
               state_in      = ret_ff;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ret_ff        <= S_IDLE;
         now_ff        <= '0;
         stamp_ff      <= '0;
         valid_ff      <= '0;
         cnt_ff        <= '0;
         cmp_vld_ff    <= 1'b0;
         rm_ff         <= '0;
         best_found_ff <= 1'b0;
         pend_ff       <= 1'b0;
         nfire_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         now_ff        <= now_in;
         stamp_ff      <= stamp_in;
         valid_ff      <= valid_in;
         cnt_ff        <= cnt_in;
         cmp_vld_ff    <= cmp_vld_in;
         rm_ff         <= rm_in;
         best_found_ff <= best_found_in;
         pend_ff       <= pend_in;
         nfire_ff      <= nfire_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      id_ff         <= id_in;
      opb_ff        <= opb_in;
      sdl_ff        <= sdl_in;
      cmp_idx_ff    <= cmp_idx_in;
      best_idx_ff   <= best_idx_in;
      best_dl_ff    <= best_dl_in;
      best_age_ff   <= best_age_in;
      best_task_ff  <= best_task_in;
      pend_task_ff  <= pend_task_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_count_ff  <= res_count_in;
      res_last_ff   <= res_last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

`ifndef ASSERT_OFF
   a_fire_limit: assert property (@(posedge clock) disable iff (reset)
      nfire_ff <= N_END)
      else $error("tick fired more entries than the result limit");

   a_write_free: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !valid_ff[wr_addr])
      else $error("schedule overwrote a live slot");

   a_write_sets: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> valid_ff[$past(wr_addr)])
      else $error("scheduled slot not marked valid");

   a_none_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_NONE)) |-> (rsp_last_ff && (rsp_id_ff == '0)))
      else $error("nothing-due word must be final with zero id");

   a_count_cancel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_count_ff != '0)) |-> (rsp_status_ff == ST_CANCEL))
      else $error("removal count on a non-cancel word");
`endif

endmodule
`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the deadline timer queue: directed and random request words.
module testbench
   import dtq_pkg::*;
();

   // Table geometry of the block under test, and the one kind code it leaves unnamed.
   localparam int          DEPTH        = TABLE_DEPTH_DEF;
   localparam logic [15:0] ID_MASK      = 16'((32'd1 << TASK_ID_BITS_DEF) - 1);
   localparam logic [1:0]  KIND_UNKNOWN = 2'd3;
   localparam int          FAULT_SHOWN  = 10;

   // One result word as it leaves on rsp_*.
   typedef struct packed {
      logic [2:0]         status;
      logic [ID_W-1:0]    task_id;
      logic [COUNT_W-1:0] removed;
      logic               last;
   } rsp_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_kind = KIND_TICK;
   logic [15:0] req_task_id = '0;
   logic [31:0] req_delay_ms = '0;
   logic [15:0] req_elapsed_ms = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_fired_id;
   logic [5:0]  rsp_removed_count;
   logic        rsp_last;

   // Predicted timer state: clock, insertion stamp and the slot table.
   logic [TIME_W-1:0]  clk_ms = '0;
   logic [STAMP_W-1:0] stamp_next = '0;
   bit                 slot_used [DEPTH];
   logic [TIME_W-1:0]  slot_due [DEPTH];
   logic [ID_W-1:0]    slot_task [DEPTH];
   logic [STAMP_W-1:0] slot_stamp [DEPTH];

   // Result words still owed by the block, oldest first.
   rsp_word_type timer_results_q[$];

   int           fault_count = 0;
   int unsigned  send_gap_max = 9;
   int unsigned  sink_gap_max = 9;
   int unsigned  sink_hold = 0;
   int unsigned  sink_draw;
   rsp_word_type got_word;
   rsp_word_type want_word;

   deadline_timer_queue_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_kind          (req_kind),
      .req_task_id       (req_task_id),
      .req_delay_ms      (req_delay_ms),
      .req_elapsed_ms    (req_elapsed_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_fired_id      (rsp_fired_id),
      .rsp_removed_count (rsp_removed_count),
      .rsp_last          (rsp_last)
   );

   always #5 clock = ~clock;

   // Hard stop in case the block hangs or loses a word.
   initial begin
      #40000000;
      $display("testbench: done, errors");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------------

   function automatic void queue_result(input logic [2:0] status, input logic [ID_W-1:0] id,
                                        input logic [COUNT_W-1:0] removed, input logic last);
      rsp_word_type w;
      w.status  = status;
      w.task_id = id;
      w.removed = removed;
      w.last    = last;
      timer_results_q = {timer_results_q, w};
   endfunction

   // Apply one accepted request word to the predicted table and queue the words it causes.
   function automatic void timer_queue_step(input logic [1:0] kind, input logic [15:0] id_in,
                                            input logic [31:0] delay,
                                            input logic [15:0] elapsed);
      logic [TIME_W:0]    sum;
      logic [ID_W-1:0]    id;
      logic [STAMP_W-1:0] age;
      logic [STAMP_W-1:0] best_age;
      int                 slot;
      int                 best;
      int                 fired;
      int unsigned        removed;
      bit                 drained;
      id = id_in & ID_MASK;
      case (kind)
         KIND_SCHED: begin
            slot = -1;
            for (int i = 0; i < DEPTH; i++)
               if (!slot_used[i] && slot < 0) slot = i;
            if (slot < 0) begin
               queue_result(ST_FULL, id, '0, 1'b1);
            end else begin
               // saturate the deadline at the top of the 48-bit clock
               sum = {1'b0, clk_ms} + {17'd0, delay};
               slot_used[slot]  = 1'b1;
               slot_due[slot]   = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
               slot_task[slot]  = id;
               slot_stamp[slot] = stamp_next;
               stamp_next       = stamp_next + 1'b1;
               queue_result(ST_SCHED, id, '0, 1'b1);
            end
         end
         KIND_CANCEL: begin
            removed = 0;
            for (int i = 0; i < DEPTH; i++) begin
               if (slot_used[i] && slot_task[i] == id) begin
                  slot_used[i] = 1'b0;
                  removed++;
               end
            end
            if (removed > COUNT_MAX) removed = COUNT_MAX;
            queue_result(ST_CANCEL, id, COUNT_W'(removed), 1'b1);
         end
         KIND_TICK: begin
            sum    = {1'b0, clk_ms} + {33'd0, elapsed};
            clk_ms = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            fired   = 0;
            drained = 1'b0;
            // earliest deadline first, oldest insertion first within a tie
            while (fired < MAX_RESULTS && !drained) begin
               best     = -1;
               best_age = '0;
               for (int i = 0; i < DEPTH; i++) begin
                  if (slot_used[i] && slot_due[i] <= clk_ms) begin
                     age = stamp_next - slot_stamp[i];
                     if (best < 0 || slot_due[i] < slot_due[best] ||
                         (slot_due[i] == slot_due[best] && age > best_age)) begin
                        best     = i;
                        best_age = age;
                     end
                  end
               end
               if (best < 0) begin
                  drained = 1'b1;
               end else begin
                  slot_used[best] = 1'b0;
                  queue_result(ST_FIRED, slot_task[best], '0, 1'b0);
                  fired++;
               end
            end
            if (fired == 0)
               queue_result(ST_NONE, '0, '0, 1'b1);
            else
               timer_results_q[timer_results_q.size() - 1].last = 1'b1;
         end
         default: ;  // unknown kind: no change, no word
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // Result side: random back-pressure and the comparison against the oldest prediction
   // ---------------------------------------------------------------------------------------

   // Drop ready for a freshly drawn hold after every word taken; a draw of zero keeps it high.
   always @(posedge clock) begin
      if (reset) begin
         sink_hold <= 0;
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         sink_draw = $urandom_range(0, sink_gap_max);
         sink_hold <= sink_draw;
         rsp_ready <= (sink_draw == 0);
      end else if (sink_hold != 0) begin
         sink_hold <= sink_hold - 1;
         rsp_ready <= (sink_hold == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic report_fault(input string what, input rsp_word_type want,
                               input rsp_word_type got);
      string want_s;
      string got_s;
      fault_count++;
      if (fault_count <= FAULT_SHOWN) begin
         want_s = $sformatf("st=%0d id=%h cnt=%0d last=%b",
                            want.status, want.task_id, want.removed, want.last);
         got_s  = $sformatf("st=%0d id=%h cnt=%0d last=%b",
                            got.status, got.task_id, got.removed, got.last);
         $display("%0t %s: expected %s, got %s", $realtime, what, want_s, got_s);
      end
   endtask

   // Compare every word taken with the oldest prediction; flag words nobody asked for.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_word = '{rsp_status, rsp_fired_id, rsp_removed_count, rsp_last};
         if (timer_results_q.size() == 0) begin
            report_fault("unexpected word", '0, got_word);
         end else begin
            want_word = timer_results_q.pop_front();
            if (got_word !== want_word) report_fault("mismatch", want_word, got_word);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------------

   // Wait a drawn gap, present one request word, hold it until taken, then predict.
   task automatic send_word(input logic [1:0] kind, input logic [15:0] id,
                            input logic [31:0] delay, input logic [15:0] elapsed);
      int unsigned gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_task_id    <= id;
      req_delay_ms   <= delay;
      req_elapsed_ms <= elapsed;
      do @(posedge clock); while (!req_ready);
      timer_queue_step(kind, id, delay, elapsed);
   endtask

   // Release the request channel and hold off until every owed word has come back.
   task automatic wait_all_answered();
      req_valid <= 1'b0;
      do @(posedge clock); while (timer_results_q.size() != 0);
   endtask

   function automatic int free_slots();
      int n;
      n = 0;
      for (int i = 0; i < DEPTH; i++)
         if (!slot_used[i]) n++;
      return n;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Tick on an empty table straight out of reset: nothing due.
   task automatic test_empty_tick();
      send_word(KIND_TICK, 16'h0000, 32'h0000_0000, 16'h0000);
   endtask

   // Field extremes, the unknown kind, cancel of an absent task.
   task automatic test_field_extremes();
      send_word(KIND_SCHED, 16'h0000, 32'h0000_0000, 16'h0000);
      send_word(KIND_SCHED, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_word(KIND_SCHED, 16'hA5A5, 32'h5A5A_A5A5, 16'h5A5A);
      send_word(KIND_UNKNOWN, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_word(KIND_UNKNOWN, 16'h0000, 32'h0000_0000, 16'h0000);
      // zero-length advance still fires the zero-delay entry
      send_word(KIND_TICK, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000);
      send_word(KIND_TICK, 16'h0000, 32'h0000_0000, 16'hFFFF);
      send_word(KIND_CANCEL, 16'h1234, 32'h0000_0000, 16'h0000);
      send_word(KIND_CANCEL, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_word(KIND_CANCEL, 16'hA5A5, 32'h0000_0000, 16'h0000);
   endtask

   // Ties broken by insertion order even when a newer entry sits in a lower slot;
   // cancel with several matches. Run without idling on either side.
   task automatic test_tie_order();
      send_gap_max = 0;
      sink_gap_max = 0;
      send_word(KIND_SCHED, 16'd1, 32'd50, 16'd0);
      send_word(KIND_SCHED, 16'd2, 32'd50, 16'd0);
      send_word(KIND_SCHED, 16'd3, 32'd30, 16'd0);
      send_word(KIND_CANCEL, 16'd1, 32'd0, 16'd0);
      send_word(KIND_SCHED, 16'd4, 32'd50, 16'd0);
      send_word(KIND_SCHED, 16'd5, 32'd30, 16'd0);
      send_word(KIND_SCHED, 16'd7, 32'd90, 16'd0);
      send_word(KIND_SCHED, 16'd7, 32'd90, 16'd0);
      send_word(KIND_TICK, 16'd0, 32'd0, 16'd29);
      send_word(KIND_TICK, 16'd0, 32'd0, 16'd1);
      send_word(KIND_TICK, 16'd0, 32'd0, 16'd20);
      send_word(KIND_CANCEL, 16'd7, 32'd0, 16'd0);
      send_gap_max = 9;
      sink_gap_max = 9;
   endtask

   // Fill every slot, hold off until all answered, overflow once, then fire the lot.
   task automatic test_table_full();
      int tag;
      tag = 0;
      while (free_slots() != 0) begin
         send_word(KIND_SCHED, 16'(16'h0100 + tag), 32'($urandom_range(0, 3) * 5), 16'd0);
         tag++;
      end
      wait_all_answered();
      send_word(KIND_SCHED, 16'hBEEF, 32'd1, 16'd0);
      send_word(KIND_TICK, 16'd0, 32'd0, 16'd15);
      send_word(KIND_TICK, 16'd0, 32'd0, 16'd0);
   endtask

   // Random traffic: mostly short delays and small task pools so entries tie, fire and
   // get cancelled; now and then full-range fields, the unknown kind and idle switches.
   task automatic test_random_traffic(input int count);
      int          pick;
      int          used_q[$];
      logic [1:0]  kind;
      logic [15:0] id;
      logic [31:0] delay;
      logic [15:0] elapsed;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 39) == 0) send_gap_max = (send_gap_max == 0) ? 9 : 0;
         if ($urandom_range(0, 39) == 0) sink_gap_max = (sink_gap_max == 0) ? 9 : 0;
         pick    = $urandom_range(0, 99);
         id      = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
         delay   = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 40) * 5);
         elapsed = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
         if (pick < 45) begin
            kind = KIND_SCHED;
         end else if (pick < 78) begin
            kind = KIND_TICK;
         end else if (pick < 95) begin
            kind = KIND_CANCEL;
            // mostly aim at a task that is really pending
            used_q = {};
            for (int i = 0; i < DEPTH; i++)
               if (slot_used[i]) used_q = {used_q, i};
            if (used_q.size() != 0 && $urandom_range(0, 9) < 7)
               id = slot_task[used_q[$urandom_range(0, used_q.size() - 1)]];
         end else begin
            kind = KIND_UNKNOWN;
         end
         send_word(kind, id, delay, elapsed);
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_tick();
      test_field_extremes();
      test_tie_order();
      test_table_full();
      test_random_traffic(370);
      // drain, then keep watching for any stray word before the verdict
      wait_all_answered();
      repeat (4 * (DEPTH + 4)) @(posedge clock);
      if (fault_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
